// ===== hw/rtl/oal_pkg.sv =====
package oal_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int ACT_W = 3;
    localparam int POS_W = 9;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR    = 3'd0,
        ACT_INSERT   = 3'd1,
        ACT_DELETE   = 3'd2,
        ACT_LOCATE   = 3'd3,
        ACT_RETRIEVE = 3'd4,
        ACT_DELALL   = 3'd5
    } action_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_BADPOS = 2'd2,
        STS_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

// ===== hw/rtl/oal_if.sv =====
interface oal_req_if;
    import oal_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface oal_rsp_if;
    import oal_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STS_W-1:0]        status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        removed_count;
    logic [POS_W-1:0]        list_length;

    modport source (output valid, output status, output found_position, output read_value,
                    output removed_count, output list_length, input ready);
    modport sink   (input valid, input status, input found_position, input read_value,
                    input removed_count, input list_length, output ready);
endinterface

// ===== hw/rtl/oal_ram.sv =====
module oal_ram #(
    parameter int DEPTH  = oal_pkg::CAPACITY_DEF,
    parameter int DATA_W = oal_pkg::VAL_W,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== hw/rtl/ordered_array_list_unit.sv =====
// Ordered list of signed 32-bit values held in a single-port-read,
// single-port-write RAM of CAPACITY entries, plus a length register.
// Requests arrive on the req channel (action, position, value) and each
// produces exactly one item on the rsp channel (status, found position,
// read value, removed count, length after the request).
// The unit works on one request at a time. Clear, unused action codes and
// failed checks (full, bad position, empty) skip the walk and go straight
// to the finish state, which loads the output register once it is free and
// then returns to idle to take the next request. Insert, delete, locate,
// retrieve and delete-all walk the RAM one entry per cycle, reading up to
// the list length of entries (at most CAPACITY, possibly none) before they
// pass through the finish state in the same way.
// The walk is bound by the one RAM read port and its registered reads;
// insert and delete write each read's data back in the cycle after the
// read, and delete-all writes back only entries unequal to the value.
// Reset clears the length and all control state; RAM contents are left
// undefined and never read before they are written.
// The result sits in an output register. If the receiver stalls, the unit
// still accepts and works the next request, and holds its result until the
// output register frees up.
module ordered_array_list_unit #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    oal_req_if.sink   req,
    oal_rsp_if.source rsp
);
    import oal_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Control state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    // Working payload.
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [ADDR_W-1:0] ins_addr_reg, ins_addr_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    status_t           sts_reg, sts_next;
    logic [CNT_W-1:0]  fpos_reg, fpos_next;
    logic [VAL_W-1:0]  rval_reg, rval_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    // Output register.
    logic [STS_W-1:0]  out_sts_reg, out_sts_next;
    logic [POS_W-1:0]  out_fpos_reg, out_fpos_next;
    logic [VAL_W-1:0]  out_rval_reg, out_rval_next;
    logic [POS_W-1:0]  out_rem_reg, out_rem_next;
    logic [POS_W-1:0]  out_len_reg, out_len_next;

    // RAM port signals.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [VAL_W-1:0]  ram_wr_data;
    logic              ram_rd_en;
    logic [VAL_W-1:0]  ram_rd_data;

    logic [CMP_W-1:0]  req_pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              accept;
    logic              out_free;

    oal_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (VAL_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign req_pos_ext = CMP_W'(req.position);
    assign cnt_ext     = CMP_W'(count_reg);

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_sts_reg;
    assign rsp.found_position = out_fpos_reg;
    assign rsp.read_value     = out_rval_reg;
    assign rsp.removed_count  = out_rem_reg;
    assign rsp.list_length    = out_len_reg;

    always_comb
    begin
        logic [CMP_W-1:0] span;
        logic [CMP_W-1:0] wide_fpos;
        logic [CMP_W-1:0] wide_rem;
        logic [CMP_W-1:0] wide_len;

        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;
        act_next       = act_reg;
        ins_addr_next  = ins_addr_reg;
        val_next       = val_reg;
        rd_addr_next   = rd_addr_reg;
        pend_addr_next = pend_addr_reg;
        wr_ptr_next    = wr_ptr_reg;
        sts_next       = sts_reg;
        fpos_next      = fpos_reg;
        rval_next      = rval_reg;
        rem_next       = rem_reg;
        out_sts_next   = out_sts_reg;
        out_fpos_next  = out_fpos_reg;
        out_rval_next  = out_rval_reg;
        out_rem_next   = out_rem_reg;
        out_len_next   = out_len_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = val_reg;
        ram_rd_en      = 1'b0;
        span           = '0;
        wide_fpos      = CMP_W'(fpos_reg);
        wide_rem       = CMP_W'(rem_reg);
        wide_len       = CMP_W'(count_reg);

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next    = req.action;
                    val_next    = req.value;
                    sts_next    = STS_OK;
                    fpos_next   = '0;
                    rval_next   = '0;
                    rem_next    = '0;
                    wr_ptr_next = '0;
                    remain_next = '0;
                    state_next  = ST_FINISH;
                    case (req.action)
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_INSERT:
                        begin
                            if (cnt_ext >= CMP_W'(CAPACITY))
                            begin
                                sts_next = STS_FULL;
                            end
                            else if (req_pos_ext == '0 || req_pos_ext > cnt_ext + 1'b1)
                            begin
                                sts_next = STS_BADPOS;
                            end
                            else
                            begin
                                // Shift entries p-1 .. n-1 up by one, top first.
                                span          = cnt_ext - req_pos_ext + 1'b1;
                                remain_next   = span[CNT_W-1:0];
                                rd_addr_next  = ADDR_W'(cnt_ext - 1'b1);
                                ins_addr_next = ADDR_W'(req_pos_ext - 1'b1);
                                state_next    = ST_WALK;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                sts_next = STS_EMPTY;
                            end
                            else if (req_pos_ext == '0 || req_pos_ext > cnt_ext)
                            begin
                                sts_next = STS_BADPOS;
                            end
                            else
                            begin
                                // Shift entries p .. n-1 down by one, bottom first.
                                span         = cnt_ext - req_pos_ext;
                                remain_next  = span[CNT_W-1:0];
                                rd_addr_next = ADDR_W'(req_pos_ext);
                                state_next   = ST_WALK;
                            end
                        end
                        ACT_LOCATE:
                        begin
                            remain_next  = count_reg;
                            rd_addr_next = '0;
                            state_next   = ST_WALK;
                        end
                        ACT_RETRIEVE:
                        begin
                            if (count_reg == '0)
                            begin
                                sts_next = STS_EMPTY;
                            end
                            else if (req_pos_ext == '0 || req_pos_ext > cnt_ext)
                            begin
                                sts_next = STS_BADPOS;
                            end
                            else
                            begin
                                remain_next  = CNT_W'(1);
                                rd_addr_next = ADDR_W'(req_pos_ext - 1'b1);
                                state_next   = ST_WALK;
                            end
                        end
                        ACT_DELALL:
                        begin
                            if (count_reg == '0)
                            begin
                                sts_next = STS_EMPTY;
                            end
                            else
                            begin
                                remain_next  = count_reg;
                                rd_addr_next = '0;
                                state_next   = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // Issue the next read.
                if (remain_reg != '0)
                begin
                    ram_rd_en      = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg;
                    remain_next    = remain_reg - 1'b1;
                    if (act_reg == ACT_INSERT)
                    begin
                        rd_addr_next = rd_addr_reg - 1'b1;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end

                // Consume the data read in the previous cycle.
                if (pend_reg)
                begin
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = pend_addr_reg + 1'b1;
                            ram_wr_data = ram_rd_data;
                        end
                        ACT_DELETE:
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = pend_addr_reg - 1'b1;
                            ram_wr_data = ram_rd_data;
                        end
                        ACT_LOCATE:
                        begin
                            if (fpos_reg == '0 && ram_rd_data == val_reg)
                            begin
                                fpos_next = CNT_W'(pend_addr_reg) + 1'b1;
                            end
                        end
                        ACT_RETRIEVE:
                        begin
                            rval_next = ram_rd_data;
                        end
                        ACT_DELALL:
                        begin
                            if (ram_rd_data != val_reg)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = wr_ptr_reg[ADDR_W-1:0];
                                ram_wr_data = ram_rd_data;
                                wr_ptr_next = wr_ptr_reg + 1'b1;
                            end
                            else
                            begin
                                rem_next = rem_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                // Walk finished: close out the request.
                if (remain_reg == '0 && !pend_reg)
                begin
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = ins_addr_reg;
                            ram_wr_data = val_reg;
                            count_next  = count_reg + 1'b1;
                        end
                        ACT_DELETE:
                        begin
                            count_next = count_reg - 1'b1;
                            rem_next   = CNT_W'(1);
                        end
                        ACT_DELALL:
                        begin
                            count_next = wr_ptr_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sts_next   = sts_reg;
                    out_fpos_next  = wide_fpos[POS_W-1:0];
                    out_rval_next  = rval_reg;
                    out_rem_next   = wide_rem[POS_W-1:0];
                    out_len_next   = wide_len[POS_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        ins_addr_reg  <= ins_addr_next;
        val_reg       <= val_next;
        rd_addr_reg   <= rd_addr_next;
        pend_addr_reg <= pend_addr_next;
        wr_ptr_reg    <= wr_ptr_next;
        sts_reg       <= sts_next;
        fpos_reg      <= fpos_next;
        rval_reg      <= rval_next;
        rem_reg       <= rem_next;
        out_sts_reg   <= out_sts_next;
        out_fpos_reg  <= out_fpos_next;
        out_rval_reg  <= out_rval_next;
        out_rem_reg   <= out_rem_next;
        out_len_reg   <= out_len_next;
    end
endmodule
